// ===== rtl/btnar_pkg.sv =====
// Shared types and constants for the button auto-repeat unit.
package btnar_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_STEP = 2'd2;

    localparam logic [CFG_W-1:0] RST_INIT_DELAY   = 16'd440;
    localparam logic [CFG_W-1:0] RST_REPEAT_PER   = 16'd35;
    localparam logic [CFG_W-1:0] RST_ADVANCE_STEP = 16'd40;

    typedef struct packed {
        logic [3:0]  button_index;
        logic [7:0]  key_code;
        logic        pressed;
        logic [31:0] time_ms;
    } t_req;

    typedef struct packed {
        logic [7:0] repeat_key;
        logic [3:0] repeat_button;
        logic       last_of_run;
    } t_rep;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEWP,
        S_READ,
        S_CHECK,
        S_EMIT,
        S_WB
    } t_state;

endpackage

// ===== rtl/btnar_if.sv =====
// Request and result channel interfaces of the button auto-repeat unit.
interface btnar_req_if import btnar_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface btnar_rep_if import btnar_pkg::*; ();
    logic valid;
    logic ready;
    t_rep data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/btnar_mem.sv =====
// Per-button timestamp store: one write port, one read port, registered read data.
module btnar_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/button_auto_repeat_unit.sv =====
// Button auto-repeat top level: held flags, timestamp store and repeat sequencer.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        button_index, key_code, pressed, time_ms
//   o_rep     out  valid/ready        repeat_key, repeat_button, last_of_run
//   i_cfg_*   in   write enable only  index 0..2, 16-bit data
//
// A release or an out-of-range index is handled in S_IDLE, a new press in S_NEWP.
// A held update reads its timestamps (S_READ) and checks them (S_CHECK), then gives one
// repeat per cycle while the result is not stalled (n repeats, at most MAX_REPEATS) and,
// when n > 0, writes back in S_WB: one read-modify-write pass over the timestamp store.
// Reset clears the held flags, the sequencer and the result valid flag; the
// timestamp store needs no clearing. A stalled result holds the sequencer.
module button_auto_repeat_unit import btnar_pkg::*; #(
    parameter int BUTTONS     = 16,
    parameter int MAX_REPEATS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    btnar_req_if.sink            i_req,
    btnar_rep_if.source          o_rep,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REPEATS + 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_delay, r_period, r_step;

    logic [BUTTONS-1:0]   r_held;
    logic [ADDR_W-1:0]    r_addr;
    logic [7:0]           r_key;
    logic [3:0]           r_btn;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_press;
    logic [TIME_BITS-1:0] r_next;
    logic [TIME_BITS-1:0] r_elapsed;
    logic                 r_age_ok;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    t_rep                 r_out;

    logic                   w_accept;
    logic                   w_in_range;
    logic [ADDR_W-1:0]      w_addr;
    logic [TIME_BITS-1:0]   w_now;
    logic [TIME_BITS-1:0]   w_delay_ext, w_period_ext, w_step_ext;
    logic [2*TIME_BITS-1:0] w_rdata;
    logic [TIME_BITS-1:0]   w_rd_press, w_rd_next;
    logic [TIME_BITS-1:0]   w_age, w_elapsed;
    logic [TIME_BITS-1:0]   w_elapsed_dec;
    logic [CNT_W-1:0]       w_cnt_inc;
    logic                   w_more;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_mem_we;
    logic [2*TIME_BITS-1:0] w_wdata;

    assign w_accept     = i_req.valid && i_req.ready;
    assign w_in_range   = 32'(i_req.data.button_index) < 32'(BUTTONS);
    assign w_addr       = ADDR_W'(i_req.data.button_index);
    assign w_now        = TIME_BITS'(i_req.data.time_ms);
    assign w_delay_ext  = TIME_BITS'(r_delay);
    assign w_period_ext = TIME_BITS'(r_period);
    assign w_step_ext   = TIME_BITS'(r_step);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= RST_INIT_DELAY;
            r_period <= RST_REPEAT_PER;
            r_step   <= RST_ADVANCE_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INIT_DELAY:   r_delay  <= i_cfg_data;
                CFG_REPEAT_PER:   r_period <= i_cfg_data;
                CFG_ADVANCE_STEP: r_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Timestamp store: press time in the upper half, next repeat time below
    btnar_mem #(
        .DEPTH (BUTTONS),
        .WIDTH (2 * TIME_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd_press = w_rdata[2*TIME_BITS-1:TIME_BITS];
    assign w_rd_next  = w_rdata[TIME_BITS-1:0];
    assign w_age      = r_now - w_rd_press;
    assign w_elapsed  = r_now - w_rd_next;

    assign w_elapsed_dec = r_elapsed - w_period_ext;
    assign w_cnt_inc     = r_count + 1'b1;
    assign w_more        = (w_cnt_inc < CNT_W'(MAX_REPEATS)) && (w_elapsed_dec > w_period_ext);

    assign w_out_free = !r_out_valid || o_rep.ready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    assign w_mem_we = (r_state == S_NEWP) || (r_state == S_WB);
    assign w_wdata  = (r_state == S_NEWP) ? {r_now, r_now + w_delay_ext} : {r_press, r_next};

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rep.valid = r_out_valid;
    assign o_rep.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_in_range && i_req.data.pressed) begin
                    n_state = r_held[w_addr] ? S_READ : S_NEWP;
                end
            end
            S_NEWP:  n_state = S_IDLE;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_age_ok && !r_elapsed[TIME_BITS-1] && (r_elapsed > w_period_ext)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_emit && !w_more) begin
                    n_state = S_WB;
                end
            end
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Held flags: set on a new press, drop on a release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (w_accept && w_in_range) begin
            r_held[w_addr] <= i_req.data.pressed;
        end
    end

    // Request capture and repeat datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= w_addr;
            r_key  <= i_req.data.key_code;
            r_btn  <= i_req.data.button_index;
            r_now  <= w_now;
        end
        if (r_state == S_READ) begin
            r_press   <= w_rd_press;
            r_next    <= w_rd_next;
            r_elapsed <= w_elapsed;
            r_age_ok  <= !w_age[TIME_BITS-1] && (w_age >= w_delay_ext);
        end
        if (r_state == S_CHECK) begin
            r_count <= '0;
        end
        if (w_emit) begin
            r_elapsed <= w_elapsed_dec;
            r_next    <= r_next + w_step_ext;
            r_count   <= w_cnt_inc;
            r_out.repeat_key    <= r_key;
            r_out.repeat_button <= r_btn;
            r_out.last_of_run   <= !w_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rep.ready) begin
            r_out_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count < CNT_W'(MAX_REPEATS)))
        else $error("repeat count beyond cap");

    a_emit_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_elapsed > w_period_ext))
        else $error("repeat emitted without enough elapsed time");

    a_last_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_more) |=> (r_state == S_WB) && r_out_valid && r_out.last_of_run)
        else $error("final repeat not followed by write-back");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_accept))
        else $error("store read and write in the same cycle");

    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_range && i_req.data.pressed) |=> r_held[$past(w_addr)])
        else $error("press did not mark button held");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the button auto-repeat unit, with its own repeat predictor.
module tb import btnar_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int NBTN      = 16;
    localparam int REP_CAP   = 16;
    localparam int DRAIN_CYC = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    btnar_req_if req_if ();
    btnar_rep_if rep_if ();

    button_auto_repeat_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rep      (rep_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: per-button hold tracking and shadow of the timing registers.
    logic        btn_held  [NBTN];
    logic [31:0] btn_press [NBTN];
    logic [31:0] btn_next  [NBTN];
    logic [15:0] delay_ms, period_ms, step_ms;

    t_rep        repeat_q [$];
    int          fail_cnt = 0;
    bit          calm = 1'b0;
    logic [31:0] wall_ms;

    task automatic reset_predictor();
        for (int b = 0; b < NBTN; b++) begin
            btn_held[b]  = 1'b0;
            btn_press[b] = '0;
            btn_next[b]  = '0;
        end
        delay_ms  = RST_INIT_DELAY;
        period_ms = RST_REPEAT_PER;
        step_ms   = RST_ADVANCE_STEP;
    endtask

    task automatic predict_repeats(input t_req r);
        logic [3:0]  idx;
        logic [31:0] age;
        logic [31:0] late;
        int          n;
        t_rep        e;
        idx = r.button_index;
        n   = 0;
        if (!r.pressed) begin
            btn_held[idx] = 1'b0;
            return;
        end
        if (!btn_held[idx]) begin
            btn_held[idx]  = 1'b1;
            btn_press[idx] = r.time_ms;
            btn_next[idx]  = r.time_ms + {16'd0, delay_ms};
            return;
        end
        age = r.time_ms - btn_press[idx];
        if (age[31] || age < {16'd0, delay_ms})
            return;
        late = r.time_ms - btn_next[idx];
        if (late[31])
            return;
        // drop anything beyond the cap
        while (n < REP_CAP && late > {16'd0, period_ms}) begin
            late          = late - {16'd0, period_ms};
            btn_next[idx] = btn_next[idx] + {16'd0, step_ms};
            n++;
        end
        for (int k = 0; k < n; k++) begin
            e.repeat_key    = r.key_code;
            e.repeat_button = idx;
            e.last_of_run   = (k == n - 1);
            repeat_q.push_back(e);
        end
    endtask

    function automatic t_req mk_update(input logic [3:0] b, input logic [7:0] key,
                                       input logic down, input logic [31:0] t);
        t_req r;
        r.button_index = b;
        r.key_code     = key;
        r.pressed      = down;
        r.time_ms      = t;
        return r;
    endfunction

    task automatic send_update(input t_req r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.data  = r;
        req_if.valid = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_repeats(r);
    endtask

    // Drop the request, wait for every repeat, then let the sequencer go quiet.
    task automatic settle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (repeat_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_INIT_DELAY:   delay_ms  = val;
            CFG_REPEAT_PER:   period_ms = val;
            CFG_ADVANCE_STEP: step_ms   = val;
            default: ;
        endcase
    endtask

    function automatic t_req rand_update();
        t_req        r;
        int          pick;
        logic [3:0]  b;
        int unsigned off;
        b    = 4'($urandom_range(0, NBTN - 1));
        pick = $urandom_range(0, 99);
        wall_ms = wall_ms + $urandom_range(0, 5000);
        r = mk_update(b, 8'($urandom), 1'b1, wall_ms);
        if (pick < 8) begin
            // noise: anything at any time
            r.pressed = 1'($urandom);
            r.time_ms = $urandom;
        end else if (!btn_held[b]) begin
            r.pressed = (pick < 90);
        end else if (pick < 18) begin
            r.pressed = 1'b0;
        end else begin
            off = $urandom_range(0, 20 * period_ms + 60);
            if (pick < 26)
                r.time_ms = btn_press[b] + $urandom_range(0, delay_ms);
            else if (pick < 60)
                r.time_ms = btn_press[b] + {16'd0, delay_ms} + off;
            else
                r.time_ms = btn_next[b] + off;
        end
        return r;
    endfunction

    task automatic run_random(input int n, input logic [15:0] d, input logic [15:0] p,
                              input logic [15:0] s, input bit quiet);
        write_cfg(CFG_INIT_DELAY, d);
        write_cfg(CFG_REPEAT_PER, p);
        write_cfg(CFG_ADVANCE_STEP, s);
        wall_ms = $urandom;
        for (int k = 0; k < n; k++) begin
            if (k % 30 == 0)
                calm = quiet || ($urandom_range(0, 2) == 0);
            send_update(rand_update());
        end
        settle();
        calm = 1'b0;
    endtask

    task automatic test_reset_timing();
        logic [31:0] t0;
        t0 = $urandom;
        send_update(mk_update(4'd0, 8'h00, 1'b1, t0));
        send_update(mk_update(4'd0, 8'h00, 1'b1, t0 + 100));
        send_update(mk_update(4'd0, 8'h00, 1'b1, t0 + 476));
        // same time again: the next repeat time has moved past it
        send_update(mk_update(4'd0, 8'h00, 1'b1, t0 + 476));
        send_update(mk_update(4'd0, 8'h00, 1'b1, t0 + 3000));
        send_update(mk_update(4'd0, 8'h00, 1'b0, t0 + 3001));
        send_update(mk_update(4'd0, 8'h00, 1'b0, t0 + 3002));
        settle();
    endtask

    task automatic test_time_wrap();
        send_update(mk_update(4'd15, 8'hFF, 1'b1, 32'hFFFF_FFFF));
        send_update(mk_update(4'd15, 8'hFF, 1'b1, 32'h0000_0400));
        // earlier than the press: negative age
        send_update(mk_update(4'd15, 8'hFF, 1'b1, 32'hFFFF_FFF0));
        send_update(mk_update(4'd15, 8'hFF, 1'b0, 32'h0000_0000));
        settle();
    endtask

    task automatic test_cfg_extremes();
        logic [31:0] t1;
        write_cfg(CFG_SPARE, 16'hFFFF);
        write_cfg(CFG_INIT_DELAY, 16'd0);
        write_cfg(CFG_REPEAT_PER, 16'd0);
        write_cfg(CFG_ADVANCE_STEP, 16'd0);
        t1 = $urandom;
        send_update(mk_update(4'd3, 8'h5A, 1'b1, t1));
        send_update(mk_update(4'd3, 8'h5A, 1'b1, t1));
        // zero period: only the cap ends the run
        send_update(mk_update(4'd3, 8'h5A, 1'b1, t1 + 1));
        send_update(mk_update(4'd3, 8'h5A, 1'b0, t1 + 2));
        settle();
        write_cfg(CFG_INIT_DELAY, 16'hFFFF);
        write_cfg(CFG_REPEAT_PER, 16'hFFFF);
        write_cfg(CFG_ADVANCE_STEP, 16'hFFFF);
        t1 = $urandom;
        send_update(mk_update(4'd7, 8'hA5, 1'b1, t1));
        send_update(mk_update(4'd7, 8'hA5, 1'b1, t1 + 65534));
        send_update(mk_update(4'd7, 8'hA5, 1'b1, t1 + 65535 + 65536));
        send_update(mk_update(4'd7, 8'hA5, 1'b1, t1 + 65535 * 21));
        send_update(mk_update(4'd7, 8'hA5, 1'b0, t1));
        settle();
    endtask

    task automatic test_random_default();
        run_random(130, RST_INIT_DELAY, RST_REPEAT_PER, RST_ADVANCE_STEP, 1'b0);
    endtask

    task automatic test_random_narrow();
        run_random(100, 16'($urandom_range(0, 2000)), 16'($urandom_range(1, 100)),
                   16'($urandom_range(0, 100)), 1'b0);
    endtask

    task automatic test_random_zero();
        run_random(60, 16'd0, 16'd0, 16'd0, 1'b0);
    endtask

    task automatic test_random_max();
        run_random(60, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_random_wide();
        run_random(70, 16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom), 1'b1);
    endtask

    task automatic flag(input string what, input t_rep want, input t_rep got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s: expected key %02h btn %0d last %0b, got key %02h btn %0d last %0b",
                     what, want.repeat_key, want.repeat_button, want.last_of_run,
                     got.repeat_key, got.repeat_button, got.last_of_run);
    endtask

    always @(posedge i_clk) begin
        t_rep want;
        if (i_rst_n && rep_if.valid && rep_if.ready) begin
            if (repeat_q.size() == 0) begin
                want = '0;
                flag("unexpected repeat", want, rep_if.data);
            end else begin
                want = repeat_q.pop_front();
                if (rep_if.data.repeat_key !== want.repeat_key
                        || rep_if.data.repeat_button !== want.repeat_button
                        || rep_if.data.last_of_run !== want.last_of_run)
                    flag("repeat mismatch", want, rep_if.data);
            end
        end
    end

    // Result side: before each repeat, ready may be held low for a random wait, none while calm.
    initial begin
        int w;
        rep_if.ready = 1'b0;
        forever begin
            w = calm ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                rep_if.ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            rep_if.ready = 1'b1;
            @(posedge i_clk);
            while (!(rep_if.valid && i_rst_n)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_INIT_DELAY;
        cfg_data     = '0;
        reset_predictor();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_timing();
        test_time_wrap();
        test_cfg_extremes();
        test_random_default();
        test_random_narrow();
        test_random_zero();
        test_random_max();
        test_random_wide();

        if (fail_cnt == 0 && repeat_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== button_auto_repeat_unit.f =====
rtl/btnar_pkg.sv
rtl/btnar_if.sv
rtl/btnar_mem.sv
rtl/button_auto_repeat_unit.sv
tb/tb.sv
